### src/clcd_pkg.sv
`default_nettype none

package clcd_pkg;

  localparam int COLUMNS_DEF = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_CLEAR = 3'd1,
    KIND_HOME  = 3'd2,
    KIND_FUNC  = 3'd3,
    KIND_DISP  = 3'd4,
    KIND_ENTRY = 3'd5,
    KIND_PLACE = 3'd6
  } kind_t;

  localparam logic [7:0] CMD_LINE1  = 8'hC0;
  localparam logic [7:0] CMD_LINE0  = 8'h80;
  localparam logic [7:0] COL_MASK   = 8'h0F;
  localparam logic [7:0] CMD_FUNC   = 8'b0010_0000;
  localparam logic [7:0] CMD_DISP   = 8'b0000_1000;
  localparam logic [7:0] CMD_ENTRY  = 8'b0000_0100;
  localparam logic [7:0] CMD_HOME   = 8'b0000_0011;
  localparam logic [7:0] CMD_CLEAR  = 8'b0000_0001;

  localparam logic RS_DATA  = 1'b1;
  localparam logic RS_INSTR = 1'b0;

  // one queued request: first word plus optional line-address word
  typedef struct packed {
    logic       rs;
    logic [7:0] byte0;
    logic       two;
    logic       line;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [7:0] line_cmd(input logic line);
    return line ? CMD_LINE1 : CMD_LINE0;
  endfunction

endpackage

`default_nettype wire

### src/char_lcd_cursor_command_writer_top.sv
// an accepted request is queued, then its first bus word is loaded into the output register
// throughput: one request per cycle while each makes one bus word and out_stall is low
// a line-wrapping character makes two bus words, sent one per cycle while out_stall is low
// a two-entry request queue sits between decode and the output register
// reset (rst_n low, synchronous) sets the cursor to line 0 column 0 and empties the queue
`default_nettype none

module char_lcd_cursor_command_writer_top #(
  parameter int COLUMNS = clcd_pkg::COLUMNS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_kind,
  input  wire logic [7:0] in_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_reg_select,
  output logic [7:0]      out_bus_byte,
  output logic            out_last
);

  clcd_pkg::job_t    wr_job, rd_job;
  clcd_pkg::q_stat_t q_stat;
  logic              push, pop, acc;

  assign in_stall = q_stat.full;
  assign acc      = in_valid && !in_stall;

  clcd_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .kind  (in_kind),
    .value (in_value),
    .job   (wr_job),
    .push  (push)
  );

  clcd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  clcd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job            (rd_job),
    .q_empty        (q_stat.empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_reg_select (out_reg_select),
    .out_bus_byte   (out_bus_byte),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

### src/clcd_front.sv
`default_nettype none

module clcd_front #(
  parameter int COLUMNS = clcd_pkg::COLUMNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [2:0]  kind,
  input  wire logic [7:0]  value,
  output clcd_pkg::job_t   job,
  output logic             push
);

  logic [3:0] col_r, col_nxt;
  logic       line_r, line_nxt;
  logic [4:0] col_inc;
  logic       wrap;
  logic       emit;

  assign col_inc = {1'b0, col_r} + 5'd1;
  assign wrap    = (col_inc >= 5'(COLUMNS));

  always_comb begin
    col_nxt   = col_r;
    line_nxt  = line_r;
    job.rs    = clcd_pkg::RS_INSTR;
    job.byte0 = value;
    job.two   = 1'b0;
    job.line  = line_r;
    emit      = 1'b1;
    unique case (kind)
      clcd_pkg::KIND_CHAR: begin
        job.rs = clcd_pkg::RS_DATA;
        if (wrap) begin
          col_nxt  = 4'd0;
          line_nxt = ~line_r;
          job.two  = 1'b1;
          job.line = ~line_r;
        end else begin
          col_nxt = col_inc[3:0];
        end
      end
      clcd_pkg::KIND_CLEAR: job.byte0 = clcd_pkg::CMD_CLEAR;
      clcd_pkg::KIND_HOME: begin
        job.byte0 = clcd_pkg::CMD_HOME;
        col_nxt   = 4'd0;
        line_nxt  = 1'b0;
      end
      clcd_pkg::KIND_FUNC:  job.byte0 = clcd_pkg::CMD_FUNC | value;
      clcd_pkg::KIND_DISP:  job.byte0 = clcd_pkg::CMD_DISP | value;
      clcd_pkg::KIND_ENTRY: job.byte0 = clcd_pkg::CMD_ENTRY | value;
      clcd_pkg::KIND_PLACE: begin
        col_nxt   = value[3:0];
        line_nxt  = |value[7:4];
        job.byte0 = clcd_pkg::line_cmd(|value[7:4]) | (value & clcd_pkg::COL_MASK);
      end
      default: emit = 1'b0;
    endcase
  end

  assign push = acc & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= 4'd0;
      line_r <= 1'b0;
    end else if (acc) begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

`default_nettype wire

### src/clcd_queue.sv
`default_nettype none

module clcd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire clcd_pkg::job_t       wr_job,
  input  wire logic                 pop,
  output clcd_pkg::job_t            rd_job,
  output clcd_pkg::q_stat_t         stat
);

  localparam int DEPTH = clcd_pkg::QUEUE_DEPTH;
  localparam int PW    = clcd_pkg::PTR_W;
  localparam int CW    = clcd_pkg::CNT_W;

  clcd_pkg::job_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign rd_job     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("queue push while full");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

### src/clcd_back.sv
`default_nettype none

module clcd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire clcd_pkg::job_t job,
  input  wire logic          q_empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               out_reg_select,
  output logic [7:0]         out_bus_byte,
  output logic               out_last
);

  logic       valid_r;
  logic       rs_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       pend_r, pend_nxt;
  logic       pline_r;
  logic       load;

  assign load = !valid_r || !out_stall;
  assign pop  = load && !pend_r && !q_empty;

  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      if (pend_r) begin
        pend_nxt = 1'b0;
      end else if (!q_empty) begin
        pend_nxt = job.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (load) begin
        valid_r <= pend_r || !q_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        rs_r   <= clcd_pkg::RS_INSTR;
        byte_r <= clcd_pkg::line_cmd(pline_r);
        last_r <= 1'b1;
      end else begin
        rs_r    <= job.rs;
        byte_r  <= job.byte0;
        last_r  <= !job.two;
        pline_r <= job.line;
      end
    end
  end

  assign out_valid      = valid_r;
  assign out_reg_select = rs_r;
  assign out_bus_byte   = byte_r;
  assign out_last       = last_r;

`ifndef ASSERT_OFF
  a_pend_first: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (valid_r && !last_r && rs_r == clcd_pkg::RS_DATA))
    else $error("pending line word without first word shown");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
